@@ hw/rtl/pip_pkg.sv @@
// Package for the point-in-polygon test unit: default sizes, field widths,
// and the configuration register map. Used by the top level and its checker.
// No dependencies.
package pip_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  // Fixed field widths.
  localparam int unsigned IDX_W      = 5;  // vertex_index
  localparam int unsigned CNT_W      = 6;  // vertex_count and crossings
  localparam int unsigned OUT_DATA_W = 8;  // inside_res + crossings, byte padded

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register index, taken from the word address bit of paddr (paddr[2]).
  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0
  } reg_idx_t;

  // Input item kinds carried on tuser.
  typedef enum logic [0:0] {
    ACT_WRITE_VERTEX = 1'b0,
    ACT_TEST_POINT   = 1'b1
  } action_t;

endpackage

@@ hw/rtl/point_in_polygon_test_unit.sv @@
// Top level of the point-in-polygon test unit: vertex memory, edge walker
// and cross-multiplication pipeline. Depends on pip_pkg.
//
// This block keeps up to MAX_VERTICES polygon vertices in an on-chip memory
// and answers point queries by even-odd ray casting over the closed polygon
// formed by the first vertex_count vertices. A write item (tuser = 0) stores
// one vertex and leaves the input ready. A test item (tuser = 1) walks the
// polygon one edge per cycle through the single read port of the vertex
// memory: it reads vertices 0 .. n-1 and then vertex 0 again to close the
// polygon, where n is vertex_count limited to MAX_VERTICES, and holds the
// input until its result is loaded for output. The crossing test is
// exact, using a sign-correct cross-multiplication instead of a division.
// The result is held in an output register, so a new item is accepted while
// an earlier result still waits to be taken. Vertices must be written before
// a test reads them; vertex_count should be changed only while idle.
module point_in_polygon_test_unit #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
  localparam int unsigned IN_DATA_W =
    ((pip_pkg::IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: vertex_index, coord_x, coord_y (lowest bit up), zero padded
  input  logic [IN_DATA_W-1:0]           in_tdata,
  // tuser: action
  input  logic                           in_tuser,
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: inside_res, crossings (lowest bit up), zero padded
  output logic [pip_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pip_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pip_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pip_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned KW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NW    = (KW > pip_pkg::CNT_W) ? KW : pip_pkg::CNT_W;
  localparam int unsigned AW    = (IW > pip_pkg::IDX_W) ? IW : pip_pkg::IDX_W;
  localparam int unsigned VW    = 2 * CW;
  localparam int unsigned CNT_W = pip_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r;

  // Configuration register.
  logic [CNT_W-1:0] vertex_count_r;
  logic             cfg_wr;
  pip_pkg::reg_idx_t cfg_idx;

  // Input field views.
  logic [pip_pkg::IDX_W-1:0] in_index;
  logic [CW-1:0]             in_x;
  logic [CW-1:0]             in_y;
  logic                      in_acc;
  logic                      test_acc;
  logic                      vert_wr;
  logic [AW-1:0]             idx_ext;

  // Vertex memory, y above x.
  logic [VW-1:0] mem [MAX_VERTICES];
  logic [VW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          rd_vld_r;
  logic          rd_edge_r;

  // Walker.
  logic [KW-1:0]    k_r;
  logic [NW-1:0]    cnt_ext;
  logic [KW-1:0]    n_used;
  logic             last_read;
  logic signed [CW-1:0] px_r;
  logic signed [CW-1:0] py_r;
  logic [VW-1:0]    prev_r;

  // Edge stage.
  logic signed [CW-1:0] x1, y1, x2, y2, lx, ly, hx, hy, mx;
  logic signed [CW:0]   d_a, d_b, d_c, d_d;
  logic                 e1_cond;
  logic                 e1_vld_r;
  logic                 e1_cond_r;
  logic                 e1_vert_r;
  logic signed [CW:0]   e1_a_r, e1_b_r, e1_c_r, e1_d_r;

  // Product stage.
  logic                    e2_vld_r;
  logic                    e2_cond_r;
  logic                    e2_vert_r;
  logic signed [2*CW+1:0]  e2_p1_r;
  logic signed [2*CW+1:0]  e2_p2_r;

  // Count and result.
  logic [CNT_W-1:0] cnt_r;
  logic             hit;
  logic             pipe_empty;
  logic             out_load;
  logic             out_tvalid_r;
  logic [CNT_W-1:0] out_cnt_r;

  // Configuration decode: pready is always high, word index from paddr[2].
  assign cfg_pready = 1'b1;
  assign cfg_idx    = pip_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      pip_pkg::REG_VERTEX_COUNT: cfg_prdata = pip_pkg::CFG_DATA_W'(vertex_count_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
    end else if (cfg_wr && cfg_idx == pip_pkg::REG_VERTEX_COUNT) begin
      vertex_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Input handshake: one item at a time, writes finish in the accept cycle.
  assign in_tready = (state_r == ST_IDLE);
  assign in_index  = in_tdata[pip_pkg::IDX_W-1:0];
  assign in_x      = in_tdata[pip_pkg::IDX_W +: CW];
  assign in_y      = in_tdata[pip_pkg::IDX_W + CW +: CW];
  assign in_acc    = in_tvalid && in_tready;
  assign test_acc  = in_acc && (in_tuser == pip_pkg::ACT_TEST_POINT);
  assign idx_ext   = AW'(in_index);
  assign vert_wr   = in_acc && (in_tuser == pip_pkg::ACT_WRITE_VERTEX) &&
                     ({1'b0, idx_ext} < (AW + 1)'(MAX_VERTICES));

  // Number of vertices walked: vertex_count limited to the memory size.
  assign cnt_ext   = NW'(vertex_count_r);
  assign n_used    = (cnt_ext > NW'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : KW'(cnt_ext);
  assign last_read = (k_r == n_used);

  // Read address: vertices in order, then vertex 0 again to close the polygon.
  assign rd_en   = (state_r == ST_READ);
  assign rd_addr = last_read ? '0 : k_r[IW-1:0];

  // Vertex memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (vert_wr) begin
      mem[IW'(idx_ext)] <= {in_y, in_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer.
  assign pipe_empty = !rd_vld_r && !e1_vld_r && !e2_vld_r;
  assign out_load   = (state_r == ST_DRAIN) && pipe_empty &&
                      (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      k_r       <= '0;
      rd_vld_r  <= 1'b0;
      rd_edge_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_en;
      rd_edge_r <= rd_en && (k_r != '0);
      unique case (state_r)
        ST_IDLE: begin
          k_r <= '0;
          if (test_acc) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          k_r <= k_r + KW'(1);
          if (last_read) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Query point capture.
  always_ff @(posedge clk) begin
    if (test_acc) begin
      px_r <= $signed(in_x);
      py_r <= $signed(in_y);
    end
  end

  // Previous vertex forms the start of the next edge.
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prev_r <= rd_data_r;
    end
  end

  // Edge stage: order the edge bottom to top, range tests, differences.
  always_comb begin
    x1 = $signed(prev_r[CW-1:0]);
    y1 = $signed(prev_r[VW-1:CW]);
    x2 = $signed(rd_data_r[CW-1:0]);
    y2 = $signed(rd_data_r[VW-1:CW]);
    if (y1 < y2) begin
      lx = x1; ly = y1; hx = x2; hy = y2;
    end else begin
      lx = x2; ly = y2; hx = x1; hy = y1;
    end
    mx      = (x1 > x2) ? x1 : x2;
    e1_cond = (y1 != y2) && (py_r > ly) && (py_r <= hy) && (px_r <= mx);
    d_a     = {px_r[CW-1], px_r} - {lx[CW-1], lx};
    d_b     = {hy[CW-1], hy} - {ly[CW-1], ly};
    d_c     = {py_r[CW-1], py_r} - {ly[CW-1], ly};
    d_d     = {hx[CW-1], hx} - {lx[CW-1], lx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= rd_vld_r && rd_edge_r;
      e2_vld_r <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_cond_r <= e1_cond;
    e1_vert_r <= (x1 == x2);
    e1_a_r    <= d_a;
    e1_b_r    <= d_b;
    e1_c_r    <= d_c;
    e1_d_r    <= d_d;
  end

  // Product stage: (px - lx)(hy - ly) against (py - ly)(hx - lx).
  always_ff @(posedge clk) begin
    e2_cond_r <= e1_cond_r;
    e2_vert_r <= e1_vert_r;
    e2_p1_r   <= e1_a_r * e1_b_r;
    e2_p2_r   <= e1_c_r * e1_d_r;
  end

  // Crossing count; the point lies left of or on the edge when p1 <= p2.
  assign hit = e2_vld_r && e2_cond_r && (e2_vert_r || (e2_p1_r <= e2_p2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (test_acc) begin
      cnt_r <= '0;
    end else if (hit) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cnt_r <= cnt_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = pip_pkg::OUT_DATA_W'({out_cnt_r, out_cnt_r[0]});

endmodule

@@ hw/rtl/pip_checker.sv @@
// Port-level checker for the point-in-polygon test unit, bound to the top
// level below. Depends on pip_pkg for the action codes and result width.
module pip_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pip_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The inside flag is the parity of the crossing count.
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == out_tdata[1]))
    else $error("inside flag disagrees with crossing count");

  // A test transaction occupies the unit for at least the next cycle.
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == pip_pkg::ACT_TEST_POINT) |=> !in_tready)
    else $error("unit ready right after a test transaction");

  // A vertex write finishes in its own cycle.
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == pip_pkg::ACT_WRITE_VERTEX) |=> in_tready)
    else $error("unit stalled after a vertex write");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
